// ===== hdl/plsm_pkg.sv =====
// Shared types, codes and sizes for the positional list with sorted merge.
package plsm_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int SUM_W      = CNT_W + 1;
    localparam int WORD_W     = 32;
    localparam int CMD_W      = 4;
    localparam int POS_W      = 6;
    localparam int OIDX_W     = 6;
    localparam int STAT_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND      = 4'd0,
        CMD_INSERT_AT   = 4'd1,
        CMD_DELETE_LAST = 4'd2,
        CMD_DELETE_AT   = 4'd3,
        CMD_CLEAR_PRI   = 4'd4,
        CMD_TRAVERSE    = 4'd5,
        CMD_APPEND_SEC  = 4'd6,
        CMD_CLEAR_SEC   = 4'd7,
        CMD_MERGE       = 4'd8,
        CMD_CONCAT      = 4'd9
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        P_HOLD,
        P_APPEND,
        P_INSERT,
        P_DELETE,
        P_ROTATE
    } t_pri_op;

    typedef enum logic [1:0] {
        S_HOLD,
        S_APPEND,
        S_ROTATE
    } t_sec_op;

    // Broadcast to every cell of the chain in each cycle
    typedef struct packed {
        t_pri_op            pri_op;
        t_sec_op            sec_op;
        logic [WORD_W-1:0]  value;
        logic [POS_W-1:0]   pos;
        logic [CNT_W-1:0]   pcount;
        logic [CNT_W-1:0]   scount;
    } t_cell_ctl;

endpackage

// ===== hdl/plsm_ifs.sv =====
// Valid/ready channel interfaces for the command and result beats.
interface plsm_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic        [plsm_pkg::CMD_W-1:0]      command;
    logic signed [plsm_pkg::WORD_W-1:0]     value;
    logic        [plsm_pkg::POS_W-1:0]      position;

    modport source (output valid, output command, output value, output position,
                    input ready);
    modport sink   (input valid, input command, input value, input position,
                    output ready);
endinterface

interface plsm_res_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [plsm_pkg::WORD_W-1:0]     element;
    logic        [plsm_pkg::OIDX_W-1:0]     element_index;
    logic        [plsm_pkg::STAT_W-1:0]     status;
    logic                                   last;

    modport source (output valid, output element, output element_index,
                    output status, output last, input ready);
    modport sink   (input valid, input element, input element_index,
                    input status, input last, output ready);
endinterface

// ===== hdl/plsm_cell.sv =====
// One list slot: holds a primary word and a secondary word, moves them per broadcast op.
module plsm_cell (
    input  logic                              i_clk,
    input  logic [plsm_pkg::IDX_W-1:0]        i_idx,
    input  plsm_pkg::t_cell_ctl               i_ctl,
    input  logic [plsm_pkg::WORD_W-1:0]       i_pri_prev,
    input  logic [plsm_pkg::WORD_W-1:0]       i_pri_next,
    input  logic [plsm_pkg::WORD_W-1:0]       i_pri_head,
    input  logic [plsm_pkg::WORD_W-1:0]       i_sec_next,
    input  logic [plsm_pkg::WORD_W-1:0]       i_sec_head,
    output logic [plsm_pkg::WORD_W-1:0]       o_pri,
    output logic [plsm_pkg::WORD_W-1:0]       o_sec
);

    logic [plsm_pkg::WORD_W-1:0] r_pri, n_pri;
    logic [plsm_pkg::WORD_W-1:0] r_sec, n_sec;
    logic [plsm_pkg::POS_W-1:0]  w_idx, w_idx1, w_pcnt, w_scnt;

    assign w_idx  = plsm_pkg::POS_W'(i_idx);
    assign w_idx1 = w_idx + plsm_pkg::POS_W'(1);
    assign w_pcnt = plsm_pkg::POS_W'(i_ctl.pcount);
    assign w_scnt = plsm_pkg::POS_W'(i_ctl.scount);

    // Pick the primary word's source
    always_comb begin
        n_pri = r_pri;
        case (i_ctl.pri_op)
            plsm_pkg::P_APPEND: begin
                if (w_idx == w_pcnt) n_pri = i_ctl.value;
            end
            plsm_pkg::P_INSERT: begin
                if (w_idx == i_ctl.pos) n_pri = i_ctl.value;
                else if (w_idx > i_ctl.pos && w_idx <= w_pcnt) n_pri = i_pri_prev;
            end
            plsm_pkg::P_DELETE: begin
                if (w_idx >= i_ctl.pos && w_idx1 < w_pcnt) n_pri = i_pri_next;
            end
            plsm_pkg::P_ROTATE: begin
                if (w_idx1 < w_pcnt) n_pri = i_pri_next;
                else if (w_idx1 == w_pcnt) n_pri = i_pri_head;
            end
            default: n_pri = r_pri;
        endcase
    end

    // Pick the secondary word's source
    always_comb begin
        n_sec = r_sec;
        case (i_ctl.sec_op)
            plsm_pkg::S_APPEND: begin
                if (w_idx == w_scnt) n_sec = i_ctl.value;
            end
            plsm_pkg::S_ROTATE: begin
                if (w_idx1 < w_scnt) n_sec = i_sec_next;
                else if (w_idx1 == w_scnt) n_sec = i_sec_head;
            end
            default: n_sec = r_sec;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pri <= n_pri;
        r_sec <= n_sec;
    end

    assign o_pri = r_pri;
    assign o_sec = r_sec;

endmodule

// ===== hdl/plsm_chain.sv =====
// Row of list cells wired to their neighbors; slot zero is the head of both lists.
module plsm_chain (
    input  logic                              i_clk,
    input  plsm_pkg::t_cell_ctl               i_ctl,
    output logic [plsm_pkg::WORD_W-1:0]       o_pri_head,
    output logic [plsm_pkg::WORD_W-1:0]       o_sec_head
);

    logic [plsm_pkg::WORD_W-1:0] w_pri [plsm_pkg::LIST_DEPTH];
    logic [plsm_pkg::WORD_W-1:0] w_sec [plsm_pkg::LIST_DEPTH];

    genvar k;
    generate
        for (k = 0; k < plsm_pkg::LIST_DEPTH; k++) begin : g_cell
            logic [plsm_pkg::WORD_W-1:0] w_prev, w_pnext, w_snext;

            // End slots never take from the missing side; tie to something harmless
            if (k == 0) begin : g_first
                assign w_prev = w_pri[0];
            end else begin : g_mid
                assign w_prev = w_pri[k-1];
            end
            if (k == plsm_pkg::LIST_DEPTH - 1) begin : g_tail
                assign w_pnext = w_pri[0];
                assign w_snext = w_sec[0];
            end else begin : g_body
                assign w_pnext = w_pri[k+1];
                assign w_snext = w_sec[k+1];
            end

            plsm_cell u_cell (
                .i_clk      (i_clk),
                .i_idx      (plsm_pkg::IDX_W'(k)),
                .i_ctl      (i_ctl),
                .i_pri_prev (w_prev),
                .i_pri_next (w_pnext),
                .i_pri_head (w_pri[0]),
                .i_sec_next (w_snext),
                .i_sec_head (w_sec[0]),
                .o_pri      (w_pri[k]),
                .o_sec      (w_sec[k])
            );
        end
    endgenerate

    assign o_pri_head = w_pri[0];
    assign o_sec_head = w_sec[0];

endmodule

// ===== hdl/positional_list_with_sorted_merge_top.sv =====
// Top level: command decode, run sequencer, counts and the result register.
//
// Two lists of up to 32 signed words sit in a row of cells, one primary and one
// secondary word per cell, head at slot zero. An edit (append, insert, delete,
// clear) updates the counts, and the cells where it needs to, together, and one
// status beat follows. Traverse, concatenate and merge spend the cycle in which
// the command is taken setting up, then emit one beat per cycle while the result
// register is free, one beat per element of the run (primary count, or the sum
// of both counts), by rotating the active part of each list past the head slot;
// a run leaves both lists in their original order. Commands are taken only
// between runs, one at a time, and a new command can enter in the same cycle in
// which the last beat of the previous one is taken from the result register.
module positional_list_with_sorted_merge_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    plsm_cmd_if.sink         i_cmd,
    plsm_res_if.source       o_res
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    typedef enum logic [1:0] {
        RUN_TRAV,
        RUN_MERGE,
        RUN_CAT
    } t_run;

    t_state                         r_state, n_state;
    t_run                           r_mode, n_mode;
    logic [plsm_pkg::CNT_W-1:0]     r_pcount, n_pcount;
    logic [plsm_pkg::CNT_W-1:0]     r_scount, n_scount;
    logic [plsm_pkg::CNT_W-1:0]     r_ri, n_ri;
    logic [plsm_pkg::CNT_W-1:0]     r_rj, n_rj;

    logic                           r_out_valid, n_out_valid;
    logic [plsm_pkg::WORD_W-1:0]    r_elem, n_elem;
    logic [plsm_pkg::OIDX_W-1:0]    r_oidx, n_oidx;
    logic [plsm_pkg::STAT_W-1:0]    r_stat, n_stat;
    logic                           r_last, n_last;

    plsm_pkg::t_cell_ctl            w_ctl;
    logic [plsm_pkg::WORD_W-1:0]    w_pri_head, w_sec_head;
    logic                           w_slot_free, w_accept, w_emit;
    logic                           w_pfull, w_sfull, w_pempty, w_sempty;
    logic [plsm_pkg::POS_W-1:0]     w_pcnt_pos;
    logic [plsm_pkg::SUM_W-1:0]     w_taken, w_total;
    logic                           w_pri_left, w_sec_left, w_take_pri;

    plsm_chain u_chain (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .o_pri_head (w_pri_head),
        .o_sec_head (w_sec_head)
    );

    assign w_slot_free = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == ST_IDLE) && w_slot_free;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_emit      = (r_state == ST_RUN) && w_slot_free;

    assign w_pfull    = (r_pcount == plsm_pkg::CNT_W'(plsm_pkg::LIST_DEPTH));
    assign w_sfull    = (r_scount == plsm_pkg::CNT_W'(plsm_pkg::LIST_DEPTH));
    assign w_pempty   = (r_pcount == '0);
    assign w_sempty   = (r_scount == '0);
    assign w_pcnt_pos = plsm_pkg::POS_W'(r_pcount);

    // Run bookkeeping: elements taken so far and the run length
    assign w_taken    = plsm_pkg::SUM_W'(r_ri) + plsm_pkg::SUM_W'(r_rj);
    assign w_total    = (r_mode == RUN_TRAV) ? plsm_pkg::SUM_W'(r_pcount)
                      : plsm_pkg::SUM_W'(r_pcount) + plsm_pkg::SUM_W'(r_scount);
    assign w_pri_left = (r_ri < r_pcount);
    assign w_sec_left = (r_rj < r_scount);

    // Choose which head goes out next
    always_comb begin
        case (r_mode)
            RUN_TRAV:  w_take_pri = 1'b1;
            RUN_CAT:   w_take_pri = w_pri_left;
            RUN_MERGE: w_take_pri = w_pri_left && (!w_sec_left ||
                           ($signed(w_pri_head) < $signed(w_sec_head)));
            default:   w_take_pri = 1'b1;
        endcase
    end

    // Decode commands, sequence runs, drive the cells and the result register
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_pcount    = r_pcount;
        n_scount    = r_scount;
        n_ri        = r_ri;
        n_rj        = r_rj;
        n_out_valid = r_out_valid && !o_res.ready;
        n_elem      = r_elem;
        n_oidx      = r_oidx;
        n_stat      = r_stat;
        n_last      = r_last;

        w_ctl.pri_op = plsm_pkg::P_HOLD;
        w_ctl.sec_op = plsm_pkg::S_HOLD;
        w_ctl.value  = i_cmd.value;
        w_ctl.pos    = i_cmd.position;
        w_ctl.pcount = r_pcount;
        w_ctl.scount = r_scount;

        if (w_accept) begin
            // Default answer is one status-only beat
            n_out_valid = 1'b1;
            n_elem      = '0;
            n_oidx      = '0;
            n_stat      = plsm_pkg::STAT_OK;
            n_last      = 1'b1;
            n_ri        = '0;
            n_rj        = '0;
            unique case (plsm_pkg::t_cmd'(i_cmd.command)) inside
                plsm_pkg::CMD_APPEND: begin
                    if (w_pfull) n_stat = plsm_pkg::STAT_FULL;
                    else begin
                        w_ctl.pri_op = plsm_pkg::P_APPEND;
                        n_pcount     = r_pcount + 1'b1;
                    end
                end
                plsm_pkg::CMD_INSERT_AT: begin
                    if (w_pfull) n_stat = plsm_pkg::STAT_FULL;
                    else if (i_cmd.position > w_pcnt_pos) n_stat = plsm_pkg::STAT_RANGE;
                    else begin
                        w_ctl.pri_op = plsm_pkg::P_INSERT;
                        n_pcount     = r_pcount + 1'b1;
                    end
                end
                plsm_pkg::CMD_DELETE_LAST: begin
                    if (w_pempty) n_stat = plsm_pkg::STAT_EMPTY;
                    else n_pcount = r_pcount - 1'b1;
                end
                plsm_pkg::CMD_DELETE_AT: begin
                    if (w_pempty) n_stat = plsm_pkg::STAT_EMPTY;
                    else if (i_cmd.position >= w_pcnt_pos) n_stat = plsm_pkg::STAT_RANGE;
                    else begin
                        w_ctl.pri_op = plsm_pkg::P_DELETE;
                        n_pcount     = r_pcount - 1'b1;
                    end
                end
                plsm_pkg::CMD_CLEAR_PRI: n_pcount = '0;
                plsm_pkg::CMD_APPEND_SEC: begin
                    if (w_sfull) n_stat = plsm_pkg::STAT_FULL;
                    else begin
                        w_ctl.sec_op = plsm_pkg::S_APPEND;
                        n_scount     = r_scount + 1'b1;
                    end
                end
                plsm_pkg::CMD_CLEAR_SEC: n_scount = '0;
                plsm_pkg::CMD_TRAVERSE: begin
                    if (w_pempty) n_stat = plsm_pkg::STAT_EMPTY;
                    else begin
                        n_out_valid = 1'b0;
                        n_state     = ST_RUN;
                        n_mode      = RUN_TRAV;
                    end
                end
                plsm_pkg::CMD_MERGE, plsm_pkg::CMD_CONCAT: begin
                    if (w_pempty && w_sempty) n_stat = plsm_pkg::STAT_EMPTY;
                    else begin
                        n_out_valid = 1'b0;
                        n_state     = ST_RUN;
                        n_mode      = (plsm_pkg::t_cmd'(i_cmd.command) == plsm_pkg::CMD_MERGE)
                                    ? RUN_MERGE : RUN_CAT;
                    end
                end
                default: n_stat = plsm_pkg::STAT_RANGE;
            endcase
        end else if (w_emit) begin
            // Emit the chosen head and rotate that list by one slot
            n_out_valid = 1'b1;
            n_oidx      = plsm_pkg::OIDX_W'(w_taken);
            n_stat      = plsm_pkg::STAT_OK;
            n_last      = (w_taken + 1'b1 == w_total);
            if (w_take_pri) begin
                n_elem       = w_pri_head;
                w_ctl.pri_op = plsm_pkg::P_ROTATE;
                n_ri         = r_ri + 1'b1;
            end else begin
                n_elem       = w_sec_head;
                w_ctl.sec_op = plsm_pkg::S_ROTATE;
                n_rj         = r_rj + 1'b1;
            end
            if (n_last) n_state = ST_IDLE;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= RUN_TRAV;
            r_pcount    <= '0;
            r_scount    <= '0;
            r_ri        <= '0;
            r_rj        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_pcount    <= n_pcount;
            r_scount    <= n_scount;
            r_ri        <= n_ri;
            r_rj        <= n_rj;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_elem <= n_elem;
        r_oidx <= n_oidx;
        r_stat <= n_stat;
        r_last <= n_last;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.element       = r_elem;
    assign o_res.element_index = r_oidx;
    assign o_res.status        = r_stat;
    assign o_res.last          = r_last;

endmodule

// ===== test/positional_list_with_sorted_merge_top_tb.sv =====
// Self-checking testbench for the positional list with sorted merge top level.
module positional_list_with_sorted_merge_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plsm_pkg::*;

    localparam int RESET_CYCLES     = 9;
    localparam int HOLD_CYCLES      = 200;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int TAIL_CYCLES      = 16;
    localparam int RANDOM_PER_PHASE = 28;
    localparam int REPORT_LIMIT     = 10;

    // Command codes past the last defined one
    localparam logic [CMD_W-1:0] CMD_BAD_LO = CMD_CONCAT + 4'd1;
    localparam logic [CMD_W-1:0] CMD_BAD_HI = 4'hF;

    typedef struct packed {
        logic [WORD_W-1:0] element;
        logic [OIDX_W-1:0] element_index;
        logic [STAT_W-1:0] status;
        logic              last;
    } t_list_beat;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] value;
        logic [POS_W-1:0]  position;
        bit                has_fixed;
        t_status           fixed_status;
    } t_list_step;

    logic i_clk   = 1'b0;
    logic i_rst_n;

    plsm_cmd_if cmd_bus ();
    plsm_res_if res_bus ();

    positional_list_with_sorted_merge_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    // Shadow copy of both lists
    logic [WORD_W-1:0] pri_words [LIST_DEPTH];
    logic [WORD_W-1:0] sec_words [LIST_DEPTH];
    int                pri_cnt = 0;
    int                sec_cnt = 0;

    t_list_beat awaited_beats [$];
    int         fail_count     = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    bit         hold_token     = 1'b0;

    // Directed rows; a fixed status is typed in where it is plain to see
    t_list_step directed_steps [0:24] = '{
        '{CMD_TRAVERSE,    32'h0000_0000, 6'd0, 1'b1, STAT_EMPTY},
        '{CMD_MERGE,       32'h0000_0000, 6'd0, 1'b1, STAT_EMPTY},
        '{CMD_CONCAT,      32'h0000_0000, 6'd0, 1'b1, STAT_EMPTY},
        '{CMD_DELETE_LAST, 32'h0000_0000, 6'd0, 1'b1, STAT_EMPTY},
        '{CMD_DELETE_AT,   32'h0000_0000, 6'd0, 1'b1, STAT_EMPTY},
        '{CMD_INSERT_AT,   32'h0000_0005, 6'd1, 1'b1, STAT_RANGE},
        '{CMD_APPEND,      32'h7FFF_FFFF, 6'd0, 1'b1, STAT_OK},
        '{CMD_APPEND,      32'h8000_0000, 6'd0, 1'b1, STAT_OK},
        '{CMD_INSERT_AT,   32'hFFFF_FFFF, 6'd0, 1'b1, STAT_OK},
        '{CMD_INSERT_AT,   32'h0000_0000, 6'd3, 1'b1, STAT_OK},
        '{CMD_DELETE_AT,   32'h0000_0000, 6'd4, 1'b1, STAT_RANGE},
        '{CMD_APPEND_SEC,  32'h8000_0000, 6'd0, 1'b1, STAT_OK},
        '{CMD_APPEND_SEC,  32'h7FFF_FFFF, 6'd0, 1'b1, STAT_OK},
        '{CMD_APPEND_SEC,  32'h0000_0000, 6'd0, 1'b1, STAT_OK},
        '{CMD_TRAVERSE,    32'h0000_0000, 6'd0, 1'b0, STAT_OK},
        '{CMD_MERGE,       32'h0000_0000, 6'd0, 1'b0, STAT_OK},
        '{CMD_CONCAT,      32'h0000_0000, 6'd0, 1'b0, STAT_OK},
        '{CMD_DELETE_AT,   32'h0000_0000, 6'd1, 1'b1, STAT_OK},
        '{CMD_DELETE_LAST, 32'h0000_0000, 6'd0, 1'b1, STAT_OK},
        '{CMD_BAD_LO,      32'h0000_0000, 6'd0, 1'b1, STAT_RANGE},
        '{CMD_BAD_HI,      32'hFFFF_FFFF, 6'd63, 1'b1, STAT_RANGE},
        '{CMD_CLEAR_SEC,   32'h0000_0000, 6'd0, 1'b1, STAT_OK},
        '{CMD_MERGE,       32'h0000_0000, 6'd0, 1'b0, STAT_OK},
        '{CMD_CLEAR_PRI,   32'h0000_0000, 6'd0, 1'b1, STAT_OK},
        '{CMD_MERGE,       32'h0000_0000, 6'd0, 1'b1, STAT_EMPTY}
    };

    // Free-running clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic push_status(input logic [STAT_W-1:0] st);
        awaited_beats.push_back('{element: '0, element_index: '0, status: st, last: 1'b1});
    endtask

    task automatic push_run_beat(input logic [WORD_W-1:0] word, input int n, input int run_len);
        awaited_beats.push_back('{element: word, element_index: n[OIDX_W-1:0],
                                  status: STAT_OK, last: (n == run_len - 1)});
    endtask

    // Update the shadow lists and queue the beats one command causes
    task automatic apply_list_command(input logic [CMD_W-1:0] cmd,
                                      input logic [WORD_W-1:0] val,
                                      input logic [POS_W-1:0] pos);
        int p;
        int k;
        int i;
        int j;
        int n;
        int run_len;
        p = int'(pos);
        i = 0;
        j = 0;
        n = 0;
        case (cmd)
            CMD_APPEND: begin
                if (pri_cnt >= LIST_DEPTH) begin
                    push_status(STAT_FULL);
                end else begin
                    pri_words[pri_cnt] = val;
                    pri_cnt++;
                    push_status(STAT_OK);
                end
            end
            CMD_INSERT_AT: begin
                if (pri_cnt >= LIST_DEPTH) begin
                    push_status(STAT_FULL);
                end else if (p > pri_cnt) begin
                    push_status(STAT_RANGE);
                end else begin
                    for (k = pri_cnt; k > p; k--) pri_words[k] = pri_words[k-1];
                    pri_words[p] = val;
                    pri_cnt++;
                    push_status(STAT_OK);
                end
            end
            CMD_DELETE_LAST: begin
                if (pri_cnt == 0) begin
                    push_status(STAT_EMPTY);
                end else begin
                    pri_cnt--;
                    push_status(STAT_OK);
                end
            end
            CMD_DELETE_AT: begin
                if (pri_cnt == 0) begin
                    push_status(STAT_EMPTY);
                end else if (p >= pri_cnt) begin
                    push_status(STAT_RANGE);
                end else begin
                    for (k = p + 1; k < pri_cnt; k++) pri_words[k-1] = pri_words[k];
                    pri_cnt--;
                    push_status(STAT_OK);
                end
            end
            CMD_CLEAR_PRI: begin
                pri_cnt = 0;
                push_status(STAT_OK);
            end
            CMD_APPEND_SEC: begin
                if (sec_cnt >= LIST_DEPTH) begin
                    push_status(STAT_FULL);
                end else begin
                    sec_words[sec_cnt] = val;
                    sec_cnt++;
                    push_status(STAT_OK);
                end
            end
            CMD_CLEAR_SEC: begin
                sec_cnt = 0;
                push_status(STAT_OK);
            end
            CMD_TRAVERSE: begin
                run_len = pri_cnt;
                if (run_len == 0) push_status(STAT_EMPTY);
                for (n = 0; n < run_len; n++) push_run_beat(pri_words[n], n, run_len);
            end
            CMD_CONCAT: begin
                run_len = pri_cnt + sec_cnt;
                if (run_len == 0) push_status(STAT_EMPTY);
                for (n = 0; n < run_len; n++) begin
                    if (n < pri_cnt) push_run_beat(pri_words[n], n, run_len);
                    else             push_run_beat(sec_words[n - pri_cnt], n, run_len);
                end
            end
            CMD_MERGE: begin
                // Take primary only when strictly smaller, so ties go to secondary
                run_len = pri_cnt + sec_cnt;
                if (run_len == 0) push_status(STAT_EMPTY);
                for (n = 0; n < run_len; n++) begin
                    if (j >= sec_cnt ||
                        (i < pri_cnt && $signed(pri_words[i]) < $signed(sec_words[j]))) begin
                        push_run_beat(pri_words[i], n, run_len);
                        i++;
                    end else begin
                        push_run_beat(sec_words[j], n, run_len);
                        j++;
                    end
                end
            end
            default: begin
                push_status(STAT_RANGE);
            end
        endcase
    endtask

    // Offer one command beat, idle first at random, and predict on acceptance
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] val,
                                input logic [POS_W-1:0] pos, input bit has_fixed,
                                input t_status fixed_status);
        int mark;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.command  <= cmd;
        cmd_bus.value    <= val;
        cmd_bus.position <= pos;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        mark = awaited_beats.size();
        apply_list_command(cmd, val, pos);
        if (has_fixed) begin
            while (awaited_beats.size() > mark) void'(awaited_beats.pop_back());
            push_status(fixed_status);
        end
    endtask

    // Hold the sender until every queued beat has come back
    task automatic wait_for_drain();
        if (awaited_beats.size() != 0) begin
            cmd_bus.valid <= 1'b0;
            while (awaited_beats.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Mix of full-range words, small values that tie often, the extremes, and 17-bit signed words
    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(3))
            0:       w = $urandom;
            1:       w = WORD_W'($signed($urandom_range(8)) - 4);
            2:       w = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: w = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
        endcase
        return w;
    endfunction

    // Mostly well-formed edits and runs, with bad positions, clears and bad codes
    task automatic send_random_command();
        int r;
        r = $urandom_range(99);
        if (r < 16) begin
            send_command(CMD_APPEND, random_word(), POS_W'($urandom), 1'b0, STAT_OK);
        end else if (r < 28) begin
            send_command(CMD_INSERT_AT, random_word(), POS_W'($urandom_range(pri_cnt)),
                         1'b0, STAT_OK);
        end else if (r < 40) begin
            send_command(CMD_DELETE_AT, random_word(),
                         POS_W'(pri_cnt > 0 ? $urandom_range(pri_cnt - 1) : 0), 1'b0, STAT_OK);
        end else if (r < 48) begin
            send_command(CMD_DELETE_LAST, random_word(), POS_W'($urandom), 1'b0, STAT_OK);
        end else if (r < 62) begin
            send_command(CMD_APPEND_SEC, random_word(), POS_W'($urandom), 1'b0, STAT_OK);
        end else if (r < 68) begin
            send_command(CMD_TRAVERSE, random_word(), POS_W'($urandom), 1'b0, STAT_OK);
        end else if (r < 75) begin
            send_command(CMD_MERGE, random_word(), POS_W'($urandom), 1'b0, STAT_OK);
        end else if (r < 80) begin
            send_command(CMD_CONCAT, random_word(), POS_W'($urandom), 1'b0, STAT_OK);
        end else if (r < 84) begin
            send_command(CMD_INSERT_AT, random_word(), POS_W'($urandom_range(LIST_DEPTH)),
                         1'b0, STAT_OK);
        end else if (r < 87) begin
            send_command(CMD_DELETE_AT, random_word(), POS_W'($urandom_range(LIST_DEPTH)),
                         1'b0, STAT_OK);
        end else if (r < 92) begin
            send_command(CMD_CLEAR_PRI, random_word(), POS_W'($urandom), 1'b0, STAT_OK);
        end else if (r < 97) begin
            send_command(CMD_CLEAR_SEC, random_word(), POS_W'($urandom), 1'b0, STAT_OK);
        end else begin
            send_command(CMD_W'($urandom_range(CMD_BAD_HI, CMD_BAD_LO)), random_word(),
                         POS_W'($urandom), 1'b0, STAT_OK);
        end
    endtask

    // Fill both lists, hit the full cases, emit the longest runs, then delete and insert near the ends
    task automatic fill_both_lists();
        while (pri_cnt < LIST_DEPTH) send_command(CMD_APPEND, random_word(), '0, 1'b0, STAT_OK);
        send_command(CMD_APPEND, random_word(), '0, 1'b1, STAT_FULL);
        send_command(CMD_INSERT_AT, random_word(), POS_W'(0), 1'b1, STAT_FULL);
        send_command(CMD_INSERT_AT, random_word(), POS_W'(LIST_DEPTH), 1'b1, STAT_FULL);
        while (sec_cnt < LIST_DEPTH) send_command(CMD_APPEND_SEC, random_word(), '0, 1'b0, STAT_OK);
        send_command(CMD_APPEND_SEC, random_word(), '0, 1'b1, STAT_FULL);
        send_command(CMD_MERGE, '0, '0, 1'b0, STAT_OK);
        send_command(CMD_CONCAT, '0, '0, 1'b0, STAT_OK);
        send_command(CMD_TRAVERSE, '0, '0, 1'b0, STAT_OK);
        send_command(CMD_DELETE_AT, '0, POS_W'(LIST_DEPTH), 1'b1, STAT_RANGE);
        send_command(CMD_DELETE_AT, '0, POS_W'(LIST_DEPTH - 1), 1'b1, STAT_OK);
        send_command(CMD_DELETE_AT, '0, POS_W'(0), 1'b1, STAT_OK);
        send_command(CMD_INSERT_AT, random_word(), POS_W'(LIST_DEPTH - 2), 1'b1, STAT_OK);
    endtask

    // Stimulus: reset, directed rows, then four idling phases of random commands
    initial begin
        i_rst_n          <= 1'b0;
        cmd_bus.valid    <= 1'b0;
        cmd_bus.command  <= '0;
        cmd_bus.value    <= '0;
        cmd_bus.position <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(33, 33);
        foreach (directed_steps[s]) begin
            send_command(directed_steps[s].cmd, directed_steps[s].value,
                         directed_steps[s].position, directed_steps[s].has_fixed,
                         directed_steps[s].fixed_status);
        end
        wait_for_drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       set_idling(0, 0);
                1:       set_idling(66, 0);
                2:       set_idling(0, 66);
                default: set_idling(33, 33);
            endcase
            // Stall the result side for a long stretch while commands keep coming
            if (phase == 0) hold_token <= ~hold_token;
            if (phase == 2) fill_both_lists();
            repeat (RANDOM_PER_PHASE) send_random_command();
            wait_for_drain();
        end

        cmd_bus.valid <= 1'b0;
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && awaited_beats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Result-side ready: random stalls, plus a counted hold-off on request
    initial begin
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Compare each result beat with the oldest awaited one
    always @(posedge i_clk) begin
        t_list_beat got;
        t_list_beat want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got = '{element: res_bus.element, element_index: res_bus.element_index,
                    status: res_bus.status, last: res_bus.last};
            if (awaited_beats.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected beat: element %0d index %0d status %0d last %0b",
                             $signed(got.element), got.element_index, got.status, got.last);
            end else begin
                want = awaited_beats.pop_front();
                if (got !== want) begin
                    fail_count++;
                    // Fields in order: element, index, status, last
                    if (fail_count <= REPORT_LIMIT)
                        $display("mismatch: expected %0d,%0d,%0d,%0b got %0d,%0d,%0d,%0b",
                                 $signed(want.element), want.element_index, want.status,
                                 want.last, $signed(got.element), got.element_index,
                                 got.status, got.last);
                end
            end
        end
    end

    // Drop the run when neither channel moves a beat for too long
    always @(posedge i_clk) begin
        int quiet_cycles;
        if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
hdl/plsm_pkg.sv
hdl/plsm_ifs.sv
hdl/plsm_cell.sv
hdl/plsm_chain.sv
hdl/positional_list_with_sorted_merge_top.sv
test/positional_list_with_sorted_merge_top_tb.sv
